@@ src/ovrq_pkg.sv @@
`default_nettype none

package ovrq_pkg;

    // build defaults
    localparam int DEPTH_DEF = 16;

    // field widths
    localparam int DATA_W  = 32;
    localparam int FUNC_W  = 2;
    localparam int KIND_W  = 3;
    localparam int CFG_W   = 5;   // bits of slot_count taken from a write

    // config port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-3:0] REG_SLOT_COUNT = '0;

    localparam logic [DATA_W-1:0] EMPTY_MARK = '1;

    typedef enum logic [FUNC_W-1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_LIST   = 2'd2,
        OP_PRINT  = 2'd3
    } op_t;

    typedef enum logic [KIND_W-1:0] {
        K_REMOVED    = 3'd0,
        K_REM_EMPTY  = 3'd1,
        K_LIST_ENTRY = 3'd2,
        K_LIST_EMPTY = 3'd3,
        K_SLOT_OCC   = 3'd4,
        K_SLOT_VAC   = 3'd5
    } kind_t;

    // one decoded command between front and back
    typedef struct packed {
        op_t                      op;
        logic signed [DATA_W-1:0] value;
    } cmd_t;

endpackage

`default_nettype wire

@@ src/overwriting_ring_queue.sv @@
`default_nettype none

// Channel   Dir  Fields (low bit up)                   Transfer when
// s_        in   tuser: func[1:0]; tdata: value_in     s_tvalid & s_tready
// m_        out  tuser: kind[2:0]; tdata: value_out;   m_tvalid & m_tready
//                tlast: last
// APB       in   slot_count at byte address 0          psel & penable & pwrite
//
// Sequencing: add is done in the back sequencer's idle state; remove goes via
// ST_EMIT and the empty notices via ST_NOTE, waiting while a held m_ side keeps
// the output register full; list and print take one slot memory read per result.
// A two-entry command queue sits in front, so input is taken while the back works.
// Reset: queue empty, slot_count = DEPTH, slot words read as -1 (per-slot valid
// bits, no clearing pass). A slot_count write also empties the queue.
// Stalls: a held m_ side stops the sequencer at its output register only.
module overwriting_ring_queue #(
    parameter int DEPTH = ovrq_pkg::DEPTH_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // command stream
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [ovrq_pkg::DATA_W-1:0]  s_tdata,   // value_in
    input  wire logic [ovrq_pkg::FUNC_W-1:0]  s_tuser,   // func
    // result stream
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [ovrq_pkg::DATA_W-1:0]       m_tdata,   // value_out
    output logic [ovrq_pkg::KIND_W-1:0]       m_tuser,   // kind
    output logic                              m_tlast,
    // configuration
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [ovrq_pkg::PADDR_W-1:0] paddr,
    input  wire logic [ovrq_pkg::PDATA_W-1:0] pwdata,
    output logic [ovrq_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready
);

    localparam int SC_W = ($clog2(DEPTH+1) > ovrq_pkg::CFG_W) ?
                          $clog2(DEPTH+1) : ovrq_pkg::CFG_W;

    logic [SC_W-1:0]            slot_count_reg, slot_count_next;
    logic [ovrq_pkg::CFG_W-1:0] wr_val;
    logic                       sel_sc;
    logic                       cfg_we;
    logic                       cmd_valid, cmd_ready;
    ovrq_pkg::cmd_t             cmd;
    ovrq_pkg::kind_t            out_kind;
    logic signed [ovrq_pkg::DATA_W-1:0] out_value;

    assign pready = 1'b1;
    assign sel_sc = (paddr[ovrq_pkg::PADDR_W-1:2] == ovrq_pkg::REG_SLOT_COUNT);
    assign cfg_we = psel && penable && pwrite && pready && sel_sc;
    assign prdata = sel_sc ? ovrq_pkg::PDATA_W'(slot_count_reg) : '0;
    assign wr_val = pwdata[ovrq_pkg::CFG_W-1:0];

    // clamp the written count to 2..DEPTH
    always_comb begin
        slot_count_next = slot_count_reg;
        if (cfg_we) begin
            if (wr_val < ovrq_pkg::CFG_W'(2)) begin
                slot_count_next = SC_W'(2);
            end else if (int'(wr_val) > DEPTH) begin
                slot_count_next = SC_W'(DEPTH);
            end else begin
                slot_count_next = SC_W'(wr_val);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_count_reg <= SC_W'(DEPTH);
        end else begin
            slot_count_reg <= slot_count_next;
        end
    end

    ovrq_front u_front (
        .clk       (aclk),
        .rstn      (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    ovrq_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk        (aclk),
        .rstn       (aresetn),
        .clear      (cfg_we),
        .slot_count (slot_count_reg),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_kind     (out_kind),
        .m_value    (out_value),
        .m_last     (m_tlast)
    );

    assign m_tuser = out_kind;
    assign m_tdata = out_value;

endmodule

`default_nettype wire

@@ src/ovrq_ram.sv @@
`default_nettype none

module ovrq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

@@ src/ovrq_front.sv @@
`default_nettype none

// Accepts commands, decodes func and parks them in a two-entry queue.
module ovrq_front (
    input  wire logic                        clk,
    input  wire logic                        rstn,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [ovrq_pkg::DATA_W-1:0] s_tdata,
    input  wire logic [ovrq_pkg::FUNC_W-1:0] s_tuser,
    output logic                             cmd_valid,
    input  wire logic                        cmd_ready,
    output ovrq_pkg::cmd_t                   cmd
);

    localparam int QD   = 2;
    localparam int QA_W = $clog2(QD);
    localparam int QC_W = $clog2(QD + 1);

    ovrq_pkg::cmd_t    q_reg [QD];
    logic [QA_W-1:0]   wr_reg, wr_next;
    logic [QA_W-1:0]   rd_reg, rd_next;
    logic [QC_W-1:0]   cnt_reg, cnt_next;
    logic              push, pop;
    ovrq_pkg::cmd_t    in_cmd;

    assign s_tready  = (cnt_reg != QC_W'(QD));
    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = q_reg[rd_reg];
    assign push      = s_tvalid && s_tready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb begin
        in_cmd.op    = ovrq_pkg::op_t'(s_tuser);
        in_cmd.value = s_tdata;
    end

    always_comb begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push) begin
            wr_next = (wr_reg == QA_W'(QD - 1)) ? '0 : wr_reg + QA_W'(1);
        end
        if (pop) begin
            rd_next = (rd_reg == QA_W'(QD - 1)) ? '0 : rd_reg + QA_W'(1);
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + QC_W'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - QC_W'(1);
        end
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk) begin
        if (push) begin
            q_reg[wr_reg] <= in_cmd;
        end
    end

endmodule

`default_nettype wire

@@ src/ovrq_back.sv @@
`default_nettype none

// Ring state, slot memory and the sequencer that runs one command at a time.
module ovrq_back #(
    parameter int DEPTH = ovrq_pkg::DEPTH_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rstn,
    input  wire logic                                 clear,
    input  wire logic [$clog2(DEPTH+1) > ovrq_pkg::CFG_W ?
                       $clog2(DEPTH+1)-1 : ovrq_pkg::CFG_W-1:0] slot_count,
    input  wire logic                                 cmd_valid,
    output logic                                      cmd_ready,
    input  wire ovrq_pkg::cmd_t                       cmd,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output ovrq_pkg::kind_t                           m_kind,
    output logic signed [ovrq_pkg::DATA_W-1:0]        m_value,
    output logic                                      m_last
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int SC_W  = ($clog2(DEPTH+1) > ovrq_pkg::CFG_W) ?
                           $clog2(DEPTH+1) : ovrq_pkg::CFG_W;
    localparam int D_W   = SC_W + 1;
    localparam int DW    = ovrq_pkg::DATA_W;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_RD   = 4'b0010,
        ST_EMIT = 4'b0100,
        ST_NOTE = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic [PTR_W-1:0]    head_reg, head_next;
    logic [PTR_W-1:0]    tail_reg, tail_next;
    logic [SC_W-1:0]     fill_reg, fill_next;
    logic [DEPTH-1:0]    valid_reg, valid_next;
    ovrq_pkg::op_t       op_reg, op_next;
    logic [PTR_W-1:0]    idx_reg, idx_next;
    logic [SC_W-1:0]     cnt_reg, cnt_next;
    ovrq_pkg::kind_t     kind_reg, kind_next;
    logic                last_reg, last_next;
    logic                rdv_reg, rdv_next;

    logic                m_valid_reg, m_valid_next;
    ovrq_pkg::kind_t     m_kind_reg, m_kind_next;
    logic [DW-1:0]       m_value_reg, m_value_next;
    logic                m_last_reg, m_last_next;

    logic                ram_we, ram_re;
    logic [PTR_W-1:0]    ram_raddr;
    logic [DW-1:0]       ram_q;
    logic [PTR_W-1:0]    head_e, tail_e;
    logic [DW-1:0]       rd_word;
    logic [D_W-1:0]      gap;
    logic                occ;
    logic                out_free;

    function automatic logic [PTR_W-1:0] nxt(input logic [PTR_W-1:0] p,
                                             input logic [SC_W-1:0] sc);
        logic [SC_W-1:0] pp;
        begin
            pp = SC_W'(p) + SC_W'(1);
            nxt = (pp == sc) ? '0 : PTR_W'(pp);
        end
    endfunction

    // an empty queue restarts at slot 0 on add
    assign head_e   = (fill_reg == '0) ? '0 : head_reg;
    assign tail_e   = (fill_reg == '0) ? '0 : tail_reg;
    assign rd_word  = rdv_reg ? ram_q : ovrq_pkg::EMPTY_MARK;
    assign out_free = !m_valid_reg || m_ready;

    // print: distance of idx behind head, modulo slot_count
    always_comb begin
        gap = D_W'(idx_reg) + D_W'(slot_count) - D_W'(head_reg);
        if (gap >= D_W'(slot_count)) begin
            gap = gap - D_W'(slot_count);
        end
        occ = (fill_reg != '0) && (gap < D_W'(fill_reg));
    end

    ovrq_ram #(
        .WIDTH (DW),
        .DEPTH (DEPTH)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tail_e),
        .wdata (cmd.value),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_q)
    );

    always_comb begin
        state_next   = state_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        fill_next    = fill_reg;
        valid_next   = valid_reg;
        op_next      = op_reg;
        idx_next     = idx_reg;
        cnt_next     = cnt_reg;
        kind_next    = kind_reg;
        last_next    = last_reg;
        rdv_next     = rdv_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_kind_next  = m_kind_reg;
        m_value_next = m_value_reg;
        m_last_next  = m_last_reg;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        ram_raddr    = idx_reg;
        cmd_ready    = 1'b0;

        if (clear) begin
            valid_next = '0;
            head_next  = '0;
            tail_next  = '0;
            fill_next  = '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    cmd_ready = 1'b1;
                    if (cmd_valid) begin
                        op_next = cmd.op;
                        case (cmd.op)
                            ovrq_pkg::OP_ADD: begin
                                ram_we             = 1'b1;
                                valid_next[tail_e] = 1'b1;
                                tail_next          = nxt(tail_e, slot_count);
                                if (nxt(tail_e, slot_count) == head_e) begin
                                    // full: head moves past the oldest entry, which is dropped
                                    head_next = nxt(head_e, slot_count);
                                end else begin
                                    head_next = head_e;
                                    fill_next = fill_reg + SC_W'(1);
                                end
                            end
                            ovrq_pkg::OP_REMOVE: begin
                                if (fill_reg == '0) begin
                                    kind_next  = ovrq_pkg::K_REM_EMPTY;
                                    state_next = ST_NOTE;
                                end else begin
                                    ram_re               = 1'b1;
                                    ram_raddr            = head_reg;
                                    rdv_next             = valid_reg[head_reg];
                                    valid_next[head_reg] = 1'b0;
                                    head_next            = nxt(head_reg, slot_count);
                                    fill_next            = fill_reg - SC_W'(1);
                                    kind_next            = ovrq_pkg::K_REMOVED;
                                    last_next            = 1'b1;
                                    state_next           = ST_EMIT;
                                end
                            end
                            ovrq_pkg::OP_LIST: begin
                                if (fill_reg == '0) begin
                                    kind_next  = ovrq_pkg::K_LIST_EMPTY;
                                    state_next = ST_NOTE;
                                end else begin
                                    idx_next   = head_reg;
                                    cnt_next   = fill_reg;
                                    state_next = ST_RD;
                                end
                            end
                            default: begin
                                idx_next   = '0;
                                cnt_next   = slot_count;
                                state_next = ST_RD;
                            end
                        endcase
                    end
                end
                ST_RD: begin
                    ram_re   = 1'b1;
                    rdv_next = valid_reg[idx_reg];
                    if (op_reg == ovrq_pkg::OP_LIST) begin
                        kind_next = ovrq_pkg::K_LIST_ENTRY;
                    end else if (occ) begin
                        kind_next = ovrq_pkg::K_SLOT_OCC;
                    end else begin
                        kind_next = ovrq_pkg::K_SLOT_VAC;
                    end
                    last_next  = (cnt_reg == SC_W'(1));
                    idx_next   = nxt(idx_reg, slot_count);
                    cnt_next   = cnt_reg - SC_W'(1);
                    state_next = ST_EMIT;
                end
                ST_EMIT: begin
                    if (kind_reg == ovrq_pkg::K_REMOVED &&
                        rd_word == ovrq_pkg::EMPTY_MARK) begin
                        // dequeued the empty mark: silent
                        state_next = ST_IDLE;
                    end else if (out_free) begin
                        m_valid_next = 1'b1;
                        m_kind_next  = kind_reg;
                        m_value_next = (kind_reg == ovrq_pkg::K_SLOT_VAC) ? '0 : rd_word;
                        m_last_next  = last_reg;
                        state_next   = last_reg ? ST_IDLE : ST_RD;
                    end
                end
                ST_NOTE: begin
                    if (out_free) begin
                        m_valid_next = 1'b1;
                        m_kind_next  = kind_reg;
                        m_value_next = '0;
                        m_last_next  = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end
                default: begin
                    state_next = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            state_reg   <= ST_IDLE;
            head_reg    <= '0;
            tail_reg    <= '0;
            fill_reg    <= '0;
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            fill_reg    <= fill_next;
            valid_reg   <= valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        op_reg      <= op_next;
        idx_reg     <= idx_next;
        cnt_reg     <= cnt_next;
        kind_reg    <= kind_next;
        last_reg    <= last_next;
        rdv_reg     <= rdv_next;
        m_kind_reg  <= m_kind_next;
        m_value_reg <= m_value_next;
        m_last_reg  <= m_last_next;
    end

    assign m_valid = m_valid_reg;
    assign m_kind  = m_kind_reg;
    assign m_value = m_value_reg;
    assign m_last  = m_last_reg;

endmodule

`default_nettype wire
